/* design/ctok_pkg.sv */
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types, token codes and character helpers of the token scanner.
// ----------------------------------------------------------------------------
package ctok_pkg;

   localparam logic [7:0] K_END    = 8'd0;
   localparam logic [7:0] K_IDENT  = 8'd128;
   localparam logic [7:0] K_INT    = 8'd129;
   localparam logic [7:0] K_FLOAT  = 8'd130;
   localparam logic [7:0] K_CHAR   = 8'd131;
   localparam logic [7:0] K_STR    = 8'd132;
   localparam logic [7:0] K_LSHIFT = 8'd133;
   localparam logic [7:0] K_RSHIFT = 8'd134;
   localparam logic [7:0] K_EQ     = 8'd135;
   localparam logic [7:0] K_NOTEQ  = 8'd136;
   localparam logic [7:0] K_LTEQ   = 8'd137;
   localparam logic [7:0] K_GTEQ   = 8'd138;
   localparam logic [7:0] K_AND    = 8'd139;
   localparam logic [7:0] K_OR     = 8'd140;
   localparam logic [7:0] K_INC    = 8'd141;
   localparam logic [7:0] K_DEC    = 8'd142;
   localparam logic [7:0] K_ASSIGN = 8'd143;

   localparam logic [3:0] MOD_NONE   = 4'd0;
   localparam logic [3:0] MOD_ADD    = 4'd2;
   localparam logic [3:0] MOD_SUB    = 4'd3;
   localparam logic [3:0] MOD_MUL    = 4'd4;
   localparam logic [3:0] MOD_DIV    = 4'd5;
   localparam logic [3:0] MOD_AND    = 4'd7;
   localparam logic [3:0] MOD_OR     = 4'd8;
   localparam logic [3:0] MOD_LSHIFT = 4'd9;
   localparam logic [3:0] MOD_RSHIFT = 4'd10;

   localparam logic [2:0] E_NONE   = 3'd0;
   localparam logic [2:0] E_BAD    = 3'd1;
   localparam logic [2:0] E_QUOTE  = 3'd2;
   localparam logic [2:0] E_UNTERM = 3'd3;
   localparam logic [2:0] E_OVER   = 3'd4;
   localparam logic [2:0] E_DIGIT  = 3'd5;
   localparam logic [2:0] E_EXP    = 3'd6;

   localparam logic [4:0] RADIX_2  = 5'd2;
   localparam logic [4:0] RADIX_8  = 5'd8;
   localparam logic [4:0] RADIX_10 = 5'd10;
   localparam logic [4:0] RADIX_16 = 5'd16;

   localparam logic [31:0] INT_LIMIT_RESET = 32'd2147483647;
   localparam logic        REG_INT_LIMIT   = 1'b0;

   typedef struct packed {
      logic [7:0]  kind;
      logic [3:0]  modifier;
      logic [15:0] start_pos;
      logic [15:0] end_pos;
      logic [31:0] int_value;
      logic [7:0]  char_value;
      logic [2:0]  error_code;
      logic        last;
   } result_type;

   // Everything one source byte produces; two_res marks a second token.
   typedef struct packed {
      logic       two_res;
      result_type r0;
      result_type r1;
   } item_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd16;
      if (is_digit(c)) t = c - "0";
      else if (c >= "a" && c <= "f") t = c - "a" + 8'd10;
      else if (c >= "A" && c <= "F") t = c - "A" + 8'd10;
      return t[4:0];
   endfunction

   function automatic logic [7:0] escape_val(input logic [7:0] c);
      logic [7:0] t;
      case (c)
         "n": t = 8'd10;
         "r": t = 8'd13;
         "t": t = 8'd9;
         "v": t = 8'd11;
         "f": t = 8'd12;
         default: t = 8'd0;
      endcase
      return t;
   endfunction

endpackage

/* design/ctok_if.sv */
// ----------------------------------------------------------------------------
// ctok_if
// Valid/ready channels for source bytes and for tokens.
// ----------------------------------------------------------------------------
interface ctok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface ctok_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  kind;
   logic [3:0]  modifier;
   logic [15:0] start_pos;
   logic [15:0] end_pos;
   logic [31:0] int_value;
   logic [7:0]  char_value;
   logic [2:0]  error_code;
   logic        last;
   modport source (output valid, output kind, output modifier, output start_pos,
                   output end_pos, output int_value, output char_value,
                   output error_code, output last, input ready);
   modport sink (input valid, input kind, input modifier, input start_pos,
                 input end_pos, input int_value, input char_value,
                 input error_code, input last, output ready);
endinterface

/* design/ctok_csr.sv */
// ----------------------------------------------------------------------------
// ctok_csr
// APB-style register port holding the integer overflow limit.
// ----------------------------------------------------------------------------
module ctok_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [31:0] int_limit
);
   logic [31:0] int_limit_ff;
   logic [31:0] int_limit_in;
   logic        hit;

   assign hit = paddr[2] == ctok_pkg::REG_INT_LIMIT;
   assign pready = 1'b1;
   assign prdata = hit ? int_limit_ff : 32'd0;
   assign int_limit = int_limit_ff;

   always_comb begin
      int_limit_in = int_limit_ff;
      if (psel && penable && pwrite && hit) int_limit_in = pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_limit_ff <= ctok_pkg::INT_LIMIT_RESET;
      end else begin
         int_limit_ff <= int_limit_in;
      end
   end
endmodule

/* design/ctok_core.sv */
// ----------------------------------------------------------------------------
// ctok_core
// Scanner state and the one-byte step that closes and opens tokens.
// ----------------------------------------------------------------------------
module ctok_core #(
   parameter int POS_WIDTH   = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          ch,
   input  logic [31:0]         int_limit,
   output logic [1:0]          n_res,
   output ctok_pkg::item_type  item
);
   localparam int CW = ((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32) + 5;
   localparam logic [CW-1:0] MaskC = {{(CW-VALUE_WIDTH){1'b0}}, {VALUE_WIDTH{1'b1}}};

   typedef enum logic [3:0] {
      MD_IDLE, MD_ZERO, MD_DIG, MD_INT, MD_FRAC, MD_EXP, MD_SIGN, MD_EXPD,
      MD_COPEN, MD_CESC, MD_CCLOSE, MD_STR, MD_SESC, MD_IDENT, MD_OP1, MD_OP2
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in, tst_ff, tst_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [4:0]             rad_ff, rad_in;
   logic [7:0]             hch_ff, hch_in;
   logic [2:0]             herr_ff, herr_in;
   logic [CW-1:0]          lim_c;

   function automatic logic [15:0] pos16(input logic [POS_WIDTH-1:0] p);
      logic [POS_WIDTH+15:0] t;
      t = {16'd0, p};
      return t[15:0];
   endfunction

   function automatic ctok_pkg::result_type mk(
      input logic [7:0] k, input logic [3:0] m, input logic [POS_WIDTH-1:0] s,
      input logic [POS_WIDTH-1:0] e, input logic [VALUE_WIDTH-1:0] iv,
      input logic [7:0] cv, input logic [2:0] er);
      ctok_pkg::result_type r;
      logic [CW-1:0] ivw;
      ivw = {{(CW-VALUE_WIDTH){1'b0}}, iv};
      r.kind = k;
      r.modifier = m;
      r.start_pos = pos16(s);
      r.end_pos = pos16(e);
      r.int_value = ivw[31:0];
      r.char_value = cv;
      r.error_code = er;
      r.last = 1'b0;
      return r;
   endfunction

   always_comb begin
      lim_c = {{(CW-32){1'b0}}, int_limit};
      if (lim_c > MaskC) lim_c = MaskC;
   end

   always_comb begin
      logic                   cons, fin, fcons, acc_en, shl, go2;
      logic [7:0]             fk, fc;
      logic [3:0]             fm;
      logic [4:0]             h, d;
      logic [CW-1:0]          t, a;
      logic [1:0]             n;
      ctok_pkg::result_type   r0, r1, rx;
      logic [POS_WIDTH-1:0]   pos1;
      mode_in = mode_ff; pos_in = pos_ff; tst_in = tst_ff; acc_in = acc_ff;
      rad_in = rad_ff; hch_in = hch_ff; herr_in = herr_ff;
      cons = 1'b0; fin = 1'b0; fcons = 1'b0; acc_en = 1'b0; go2 = 1'b0;
      fk = ctok_pkg::K_END; fm = ctok_pkg::MOD_NONE; fc = 8'd0;
      h = ctok_pkg::hex_val(ch); d = h; shl = hch_ff == "<";
      n = 2'd0; r0 = '0; r1 = '0; rx = '0; t = '0; a = '0;
      pos1 = pos_ff + 1'b1;

      case (mode_ff)
         MD_ZERO: begin
            cons = 1'b1;
            if (ch == "x" || ch == "X") begin
               rad_in = ctok_pkg::RADIX_16; mode_in = MD_INT;
            end else if (ch == "b" || ch == "B") begin
               rad_in = ctok_pkg::RADIX_2; mode_in = MD_INT;
            end else if (ch == ".") begin
               herr_in = ctok_pkg::E_NONE; mode_in = MD_FRAC;
            end else if (h < 5'd16) begin
               rad_in = ctok_pkg::RADIX_8; acc_en = 1'b1;
               mode_in = ctok_pkg::is_digit(ch) ? MD_DIG : MD_INT;
            end else begin
               cons = 1'b0; fin = 1'b1; fk = ctok_pkg::K_INT;
            end
         end
         MD_DIG, MD_INT: begin
            cons = 1'b1;
            if (mode_ff == MD_DIG && ch == ".") begin
               herr_in = ctok_pkg::E_NONE; mode_in = MD_FRAC;
            end else if (h < 5'd16) begin
               acc_en = 1'b1;
               if (!ctok_pkg::is_digit(ch)) mode_in = MD_INT;
            end else begin
               cons = 1'b0; fin = 1'b1; fk = ctok_pkg::K_INT;
            end
         end
         MD_FRAC: begin
            cons = 1'b1;
            if (ch == "e" || ch == "E") mode_in = MD_EXP;
            else if (!ctok_pkg::is_digit(ch)) begin
               cons = 1'b0; fin = 1'b1; fk = ctok_pkg::K_FLOAT;
            end
         end
         MD_EXP, MD_SIGN: begin
            cons = 1'b1;
            if (mode_ff == MD_EXP && (ch == "+" || ch == "-")) mode_in = MD_SIGN;
            else if (ctok_pkg::is_digit(ch)) mode_in = MD_EXPD;
            else begin
               if (herr_in == ctok_pkg::E_NONE) herr_in = ctok_pkg::E_EXP;
               cons = 1'b0; fin = 1'b1; fk = ctok_pkg::K_FLOAT;
            end
         end
         MD_EXPD: begin
            cons = 1'b1;
            if (!ctok_pkg::is_digit(ch)) begin
               cons = 1'b0; fin = 1'b1; fk = ctok_pkg::K_FLOAT;
            end
         end
         MD_COPEN, MD_CESC: begin
            cons = 1'b1;
            if (ch == 8'd0) begin
               if (herr_in == ctok_pkg::E_NONE) herr_in = ctok_pkg::E_QUOTE;
               cons = 1'b0; fin = 1'b1; fk = ctok_pkg::K_CHAR;
            end else if (mode_ff == MD_COPEN && ch == "\\") begin
               mode_in = MD_CESC;
            end else begin
               mode_in = MD_CCLOSE;
               if (mode_ff == MD_CESC) begin
                  hch_in = ctok_pkg::escape_val(ch);
                  if (hch_in == 8'd0 && herr_in == ctok_pkg::E_NONE)
                     herr_in = ctok_pkg::E_BAD;
               end else if (ctok_pkg::is_space(ch)) begin
                  if (herr_in == ctok_pkg::E_NONE) herr_in = ctok_pkg::E_BAD;
                  hch_in = 8'd0;
               end else begin
                  hch_in = ch;
               end
            end
         end
         MD_CCLOSE: begin
            fin = 1'b1; fk = ctok_pkg::K_CHAR; fc = hch_ff;
            if (ch == "'") begin
               cons = 1'b1; fcons = 1'b1;
            end else if (herr_in == ctok_pkg::E_NONE) begin
               herr_in = ctok_pkg::E_QUOTE;
            end
         end
         MD_STR, MD_SESC: begin
            cons = 1'b1;
            if (mode_ff == MD_STR && ch == "\"") begin
               fin = 1'b1; fcons = 1'b1; fk = ctok_pkg::K_STR;
            end else if (ch == 8'd0) begin
               if (herr_in == ctok_pkg::E_NONE) herr_in = ctok_pkg::E_UNTERM;
               cons = 1'b0; fin = 1'b1; fk = ctok_pkg::K_STR;
            end else if (mode_ff == MD_SESC) begin
               if (ctok_pkg::escape_val(ch) == 8'd0 && herr_in == ctok_pkg::E_NONE)
                  herr_in = ctok_pkg::E_BAD;
               mode_in = MD_STR;
            end else if (ch == "\\") begin
               mode_in = MD_SESC;
            end
         end
         MD_IDENT: begin
            cons = 1'b1;
            if (!(ctok_pkg::is_alpha(ch) || ctok_pkg::is_digit(ch))) begin
               cons = 1'b0; fin = 1'b1; fk = ctok_pkg::K_IDENT;
            end
         end
         MD_OP1: begin
            case (hch_ff)
               "<": if (ch == "<") go2 = 1'b1;
                    else if (ch == "=") fk = ctok_pkg::K_LTEQ;
               ">": if (ch == ">") go2 = 1'b1;
                    else if (ch == "=") fk = ctok_pkg::K_GTEQ;
               "=": if (ch == "=") fk = ctok_pkg::K_EQ;
               "!": if (ch == "=") fk = ctok_pkg::K_NOTEQ;
               "|": if (ch == "|") fk = ctok_pkg::K_OR;
                    else if (ch == "=") begin
                       fk = ctok_pkg::K_ASSIGN; fm = ctok_pkg::MOD_OR;
                    end
               "&": if (ch == "&") fk = ctok_pkg::K_AND;
                    else if (ch == "=") begin
                       fk = ctok_pkg::K_ASSIGN; fm = ctok_pkg::MOD_AND;
                    end
               "+": if (ch == "+") fk = ctok_pkg::K_INC;
                    else if (ch == "=") begin
                       fk = ctok_pkg::K_ASSIGN; fm = ctok_pkg::MOD_ADD;
                    end
               "-": if (ch == "-") fk = ctok_pkg::K_DEC;
                    else if (ch == "=") begin
                       fk = ctok_pkg::K_ASSIGN; fm = ctok_pkg::MOD_SUB;
                    end
               "*": if (ch == "=") begin
                       fk = ctok_pkg::K_ASSIGN; fm = ctok_pkg::MOD_MUL;
                    end
               "/": if (ch == "=") begin
                       fk = ctok_pkg::K_ASSIGN; fm = ctok_pkg::MOD_DIV;
                    end
               default: fk = ctok_pkg::K_END;
            endcase
            if (go2) begin
               cons = 1'b1; mode_in = MD_OP2;
            end else if (fk != ctok_pkg::K_END) begin
               cons = 1'b1; fin = 1'b1; fcons = 1'b1;
            end else begin
               fin = 1'b1;
               fk = (hch_ff == "=") ? ctok_pkg::K_ASSIGN : hch_ff;
            end
         end
         MD_OP2: begin
            fin = 1'b1;
            if (ch == "=") begin
               cons = 1'b1; fcons = 1'b1; fk = ctok_pkg::K_ASSIGN;
               fm = shl ? ctok_pkg::MOD_LSHIFT : ctok_pkg::MOD_RSHIFT;
            end else begin
               fk = shl ? ctok_pkg::K_LSHIFT : ctok_pkg::K_RSHIFT;
            end
         end
         default: cons = 1'b0;
      endcase

      if (fin) begin
         r0 = mk(fk, fm, tst_ff, fcons ? pos1 : pos_ff,
                 (fk == ctok_pkg::K_INT) ? acc_ff : '0, fc, herr_in);
         n = 2'd1;
         mode_in = MD_IDLE;
      end

      // A byte the pending token did not take starts the next one.
      if (!cons) begin
         tst_in = pos_ff; herr_in = ctok_pkg::E_NONE; hch_in = 8'd0;
         acc_in = '0; rad_in = ctok_pkg::RADIX_10; mode_in = MD_IDLE;
         if (ch == 8'd0) begin
            rx = mk(ctok_pkg::K_END, ctok_pkg::MOD_NONE, pos_ff, pos_ff, '0, 8'd0,
                    ctok_pkg::E_NONE);
            if (n == 2'd0) r0 = rx; else r1 = rx;
            n = n + 2'd1;
         end else if (ctok_pkg::is_space(ch)) begin
            mode_in = MD_IDLE;
         end else if (ch == "0") begin
            mode_in = MD_ZERO;
         end else if (ctok_pkg::is_digit(ch)) begin
            mode_in = MD_DIG; acc_en = 1'b1;
         end else if (ctok_pkg::is_alpha(ch)) begin
            mode_in = MD_IDENT;
         end else if (ch == "<" || ch == ">" || ch == "=" || ch == "!" || ch == "|" ||
                      ch == "&" || ch == "+" || ch == "-" || ch == "*" || ch == "/") begin
            hch_in = ch; mode_in = MD_OP1;
         end else if (ch == "\"") begin
            mode_in = MD_STR;
         end else if (ch == "'") begin
            mode_in = MD_COPEN;
         end else if (ch == ".") begin
            mode_in = MD_FRAC;
         end else begin
            rx = mk(ch, ctok_pkg::MOD_NONE, pos_ff, pos1, '0, 8'd0,
                    ch[7] ? ctok_pkg::E_BAD : ctok_pkg::E_NONE);
            if (n == 2'd0) r0 = rx; else r1 = rx;
            n = n + 2'd1;
         end
      end

      // At most one digit is taken per byte; the radix is a shift or shift-add.
      if (acc_en) begin
         if (d >= rad_in) begin
            if (herr_in == ctok_pkg::E_NONE) herr_in = ctok_pkg::E_DIGIT;
            d = 5'd0;
         end
         a = {{(CW-VALUE_WIDTH){1'b0}}, acc_in};
         case (rad_in)
            ctok_pkg::RADIX_2:  t = a << 1;
            ctok_pkg::RADIX_8:  t = a << 3;
            ctok_pkg::RADIX_16: t = a << 4;
            default:            t = (a << 3) + (a << 1);
         endcase
         t = t + {{(CW-5){1'b0}}, d};
         if (t > lim_c) begin
            if (herr_in == ctok_pkg::E_NONE) herr_in = ctok_pkg::E_OVER;
            t = lim_c;
         end
         acc_in = t[VALUE_WIDTH-1:0];
      end

      if (ch == 8'd0) begin
         pos_in = '0; mode_in = MD_IDLE;
      end else begin
         pos_in = pos1;
      end

      r0.last = (n == 2'd1);
      r1.last = 1'b1;
      n_res = n;
      item.two_res = (n == 2'd2);
      item.r0 = r0;
      item.r1 = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MD_IDLE;
         pos_ff  <= '0;
         tst_ff  <= '0;
         acc_ff  <= '0;
         rad_ff  <= ctok_pkg::RADIX_10;
         hch_ff  <= 8'd0;
         herr_ff <= ctok_pkg::E_NONE;
      end else if (fire) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         tst_ff  <= tst_in;
         acc_ff  <= acc_in;
         rad_ff  <= rad_in;
         hch_ff  <= hch_in;
         herr_ff <= herr_in;
      end
   end
endmodule

/* design/ctok_out_queue.sv */
// ----------------------------------------------------------------------------
// ctok_out_queue
// Two-entry queue of per-byte results, delivered one token at a time.
// ----------------------------------------------------------------------------
module ctok_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ctok_pkg::item_type  push_item,
   output logic                space,
   output logic                out_valid,
   input  logic                out_ready,
   output ctok_pkg::result_type out_res
);
   ctok_pkg::item_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in, sub_ff, sub_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;
   ctok_pkg::item_type head;

   assign head = mem_ff[rp_ff];
   assign space = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_res = sub_ff ? head.r1 : head.r0;

   always_comb begin
      pop = 1'b0;
      sub_in = sub_ff;
      if (out_valid && out_ready) begin
         if (!sub_ff && head.two_res) begin
            sub_in = 1'b1;
         end else begin
            sub_in = 1'b0;
            pop = 1'b1;
         end
      end
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         sub_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         sub_ff <= sub_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

/* design/c_like_token_scanner_top.sv */
// ----------------------------------------------------------------------------
// c_like_token_scanner_top
// C-style token scanner: one source byte in, up to two tokens out.
// ----------------------------------------------------------------------------
// A token is registered into the result queue with the byte that completes it and is shown on rsp from the queue head.
// Throughput: one byte per cycle while tokens are taken; a byte that closes
// two tokens hands them out one after the other on the single result port.
// The two-entry result queue takes a byte whenever it has a free entry.
// Reset clears the scanner state, the queue and sets int_limit to 2147483647.
module c_like_token_scanner_top #(
   parameter int POS_WIDTH   = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   ctok_req_if.sink    req_bus,
   ctok_rsp_if.source  rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic                 fire, space;
   logic [31:0]          int_limit;
   logic [1:0]           n_res;
   ctok_pkg::item_type   item;
   ctok_pkg::result_type res;

   assign req_bus.ready = space;
   assign fire = req_bus.valid && space;

   ctok_csr u_csr (
      .clock(clock), .reset(reset), .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .pready(csr_pready), .int_limit(int_limit)
   );

   ctok_core #(.POS_WIDTH(POS_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) u_core (
      .clock(clock), .reset(reset), .fire(fire), .ch(req_bus.ch),
      .int_limit(int_limit), .n_res(n_res), .item(item)
   );

   ctok_out_queue u_queue (
      .clock(clock), .reset(reset), .push(fire && (n_res != 2'd0)),
      .push_item(item), .space(space), .out_valid(rsp_bus.valid),
      .out_ready(rsp_bus.ready), .out_res(res)
   );

   assign rsp_bus.kind       = res.kind;
   assign rsp_bus.modifier   = res.modifier;
   assign rsp_bus.start_pos  = res.start_pos;
   assign rsp_bus.end_pos    = res.end_pos;
   assign rsp_bus.int_value  = res.int_value;
   assign rsp_bus.char_value = res.char_value;
   assign rsp_bus.error_code = res.error_code;
   assign rsp_bus.last       = res.last;
endmodule

/* verif/ctok_checker.sv */
// ----------------------------------------------------------------------------
// ctok_checker
// Watches the source-byte and token channels of the token scanner, predicts
// the tokens each accepted byte completes and compares them field by field.
// ----------------------------------------------------------------------------
module ctok_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [7:0]           req_ch,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ctok_pkg::result_type rsp_token,
   input  logic                 cfg_we,
   input  logic [31:0]          cfg_wdata,
   output int                   fail_count,
   output int                   pending,
   output int                   token_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [4:0] {
      SC_IDLE, SC_ZERO, SC_DIG, SC_INT, SC_FRAC, SC_EXP, SC_SIGN, SC_EXPD,
      SC_COPEN, SC_CESC, SC_CCLOSE, SC_STR, SC_SESC, SC_IDENT, SC_OP1, SC_OP2
   } scan_state_type;

   scan_state_type        st;
   logic [15:0]           pos, tok_start;
   logic [31:0]           acc, limit;
   logic [4:0]            radix;
   logic [7:0]            held;
   logic [2:0]            err;
   ctok_pkg::result_type  expected_tokens[$];
   ctok_pkg::result_type  step_out[$];

   function automatic bit c_space(logic [7:0] c);
      return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
   endfunction
   function automatic bit c_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction
   function automatic bit c_alpha(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction
   function automatic logic [4:0] c_hex(logic [7:0] c);
      if (c_digit(c)) return 5'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 10);
      if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 10);
      return 5'd16;
   endfunction
   function automatic logic [7:0] c_escape(logic [7:0] c);
      case (c)
         8'h6e: return 8'd10;
         8'h72: return 8'd13;
         8'h74: return 8'd9;
         8'h76: return 8'd11;
         8'h66: return 8'd12;
         default: return 8'd0;
      endcase
   endfunction

   function automatic void flag(logic [2:0] e);
      if (err == ctok_pkg::E_NONE) err = e;
   endfunction

   function automatic void push_token(logic [7:0] k, logic [3:0] m, logic [15:0] s,
                                      logic [15:0] e, logic [31:0] iv, logic [7:0] cv,
                                      logic [2:0] ec);
      ctok_pkg::result_type t;
      t = '{k, m, s, e, iv, cv, ec, 1'b0};
      step_out.push_back(t);
   endfunction

   function automatic void close_token(logic [7:0] k, logic [3:0] m, logic [31:0] iv,
                                       logic [7:0] cv, bit consumed);
      push_token(k, m, tok_start, consumed ? pos + 16'd1 : pos, iv, cv, err);
      st = SC_IDLE;
   endfunction

   function automatic void add_digit(logic [4:0] d);
      logic [63:0] t;
      if (d >= radix) begin
         flag(ctok_pkg::E_DIGIT);
         d = 0;
      end
      t = 64'(acc) * radix + d;
      if (t > limit) begin
         flag(ctok_pkg::E_OVER);
         t = limit;
      end
      acc = t[31:0];
   endfunction

   function automatic bit op_pair(logic [7:0] c);
      logic [7:0] k;
      logic [3:0] m;
      k = 0;
      m = ctok_pkg::MOD_NONE;
      case (held)
         "<": if (c == "<") begin st = SC_OP2; return 1; end
              else if (c == "=") k = ctok_pkg::K_LTEQ;
         ">": if (c == ">") begin st = SC_OP2; return 1; end
              else if (c == "=") k = ctok_pkg::K_GTEQ;
         "=": if (c == "=") k = ctok_pkg::K_EQ;
         "!": if (c == "=") k = ctok_pkg::K_NOTEQ;
         "|": if (c == "|") k = ctok_pkg::K_OR;
              else if (c == "=") begin k = ctok_pkg::K_ASSIGN; m = ctok_pkg::MOD_OR; end
         "&": if (c == "&") k = ctok_pkg::K_AND;
              else if (c == "=") begin k = ctok_pkg::K_ASSIGN; m = ctok_pkg::MOD_AND; end
         "+": if (c == "+") k = ctok_pkg::K_INC;
              else if (c == "=") begin k = ctok_pkg::K_ASSIGN; m = ctok_pkg::MOD_ADD; end
         "-": if (c == "-") k = ctok_pkg::K_DEC;
              else if (c == "=") begin k = ctok_pkg::K_ASSIGN; m = ctok_pkg::MOD_SUB; end
         "*": if (c == "=") begin k = ctok_pkg::K_ASSIGN; m = ctok_pkg::MOD_MUL; end
         "/": if (c == "=") begin k = ctok_pkg::K_ASSIGN; m = ctok_pkg::MOD_DIV; end
         default: ;
      endcase
      if (k != 0) begin
         close_token(k, m, 0, 0, 1);
         return 1;
      end
      close_token(held == "=" ? ctok_pkg::K_ASSIGN : held, ctok_pkg::MOD_NONE, 0, 0, 0);
      return 0;
   endfunction

   // Returns 1 when the pending token swallowed the byte.
   function automatic bit continue_token(logic [7:0] c);
      logic [4:0] h;
      bit shl;
      shl = (held == "<");
      h = c_hex(c);
      case (st)
         SC_ZERO: begin
            if (c == "x" || c == "X") begin
               radix = ctok_pkg::RADIX_16; st = SC_INT; return 1;
            end
            if (c == "b" || c == "B") begin
               radix = ctok_pkg::RADIX_2; st = SC_INT; return 1;
            end
            if (c == ".") begin err = ctok_pkg::E_NONE; st = SC_FRAC; return 1; end
            if (h < 16) begin
               radix = ctok_pkg::RADIX_8;
               add_digit(h);
               st = c_digit(c) ? SC_DIG : SC_INT;
               return 1;
            end
            close_token(ctok_pkg::K_INT, ctok_pkg::MOD_NONE, acc, 0, 0);
            return 0;
         end
         SC_DIG, SC_INT: begin
            if (st == SC_DIG && c == ".") begin
               err = ctok_pkg::E_NONE; st = SC_FRAC; return 1;
            end
            if (h < 16) begin
               add_digit(h);
               if (!c_digit(c)) st = SC_INT;
               return 1;
            end
            close_token(ctok_pkg::K_INT, ctok_pkg::MOD_NONE, acc, 0, 0);
            return 0;
         end
         SC_FRAC: begin
            if (c_digit(c)) return 1;
            if (c == "e" || c == "E") begin st = SC_EXP; return 1; end
            close_token(ctok_pkg::K_FLOAT, ctok_pkg::MOD_NONE, 0, 0, 0);
            return 0;
         end
         SC_EXP, SC_SIGN: begin
            if (st == SC_EXP && (c == "+" || c == "-")) begin st = SC_SIGN; return 1; end
            if (c_digit(c)) begin st = SC_EXPD; return 1; end
            flag(ctok_pkg::E_EXP);
            close_token(ctok_pkg::K_FLOAT, ctok_pkg::MOD_NONE, 0, 0, 0);
            return 0;
         end
         SC_EXPD: begin
            if (c_digit(c)) return 1;
            close_token(ctok_pkg::K_FLOAT, ctok_pkg::MOD_NONE, 0, 0, 0);
            return 0;
         end
         SC_COPEN: begin
            if (c == 0) begin
               flag(ctok_pkg::E_QUOTE);
               close_token(ctok_pkg::K_CHAR, ctok_pkg::MOD_NONE, 0, 0, 0);
               return 0;
            end
            if (c == "\\") begin st = SC_CESC; return 1; end
            if (c_space(c)) begin flag(ctok_pkg::E_BAD); held = 0; end
            else held = c;
            st = SC_CCLOSE;
            return 1;
         end
         SC_CESC: begin
            if (c == 0) begin
               flag(ctok_pkg::E_QUOTE);
               close_token(ctok_pkg::K_CHAR, ctok_pkg::MOD_NONE, 0, 0, 0);
               return 0;
            end
            held = c_escape(c);
            if (held == 0) flag(ctok_pkg::E_BAD);
            st = SC_CCLOSE;
            return 1;
         end
         SC_CCLOSE: begin
            if (c == "'") begin
               close_token(ctok_pkg::K_CHAR, ctok_pkg::MOD_NONE, 0, held, 1);
               return 1;
            end
            flag(ctok_pkg::E_QUOTE);
            close_token(ctok_pkg::K_CHAR, ctok_pkg::MOD_NONE, 0, held, 0);
            return 0;
         end
         SC_STR: begin
            if (c == "\"") begin
               close_token(ctok_pkg::K_STR, ctok_pkg::MOD_NONE, 0, 0, 1);
               return 1;
            end
            if (c == 0) begin
               flag(ctok_pkg::E_UNTERM);
               close_token(ctok_pkg::K_STR, ctok_pkg::MOD_NONE, 0, 0, 0);
               return 0;
            end
            if (c == "\\") st = SC_SESC;
            return 1;
         end
         SC_SESC: begin
            if (c == 0) begin
               flag(ctok_pkg::E_UNTERM);
               close_token(ctok_pkg::K_STR, ctok_pkg::MOD_NONE, 0, 0, 0);
               return 0;
            end
            if (c_escape(c) == 0) flag(ctok_pkg::E_BAD);
            st = SC_STR;
            return 1;
         end
         SC_IDENT: begin
            if (c_alpha(c) || c_digit(c)) return 1;
            close_token(ctok_pkg::K_IDENT, ctok_pkg::MOD_NONE, 0, 0, 0);
            return 0;
         end
         SC_OP1: return op_pair(c);
         SC_OP2: begin
            if (c == "=") begin
               close_token(ctok_pkg::K_ASSIGN,
                           shl ? ctok_pkg::MOD_LSHIFT : ctok_pkg::MOD_RSHIFT, 0, 0, 1);
               return 1;
            end
            close_token(shl ? ctok_pkg::K_LSHIFT : ctok_pkg::K_RSHIFT, ctok_pkg::MOD_NONE,
                        0, 0, 0);
            return 0;
         end
         default: begin
            st = SC_IDLE;
            return 0;
         end
      endcase
   endfunction

   task automatic begin_token(logic [7:0] c);
      tok_start = pos;
      err = ctok_pkg::E_NONE;
      held = 0;
      acc = 0;
      radix = ctok_pkg::RADIX_10;
      if (c == 0) push_token(ctok_pkg::K_END, ctok_pkg::MOD_NONE, pos, pos, 0, 0,
                             ctok_pkg::E_NONE);
      else if (c_space(c)) ;
      else if (c == "0") st = SC_ZERO;
      else if (c_digit(c)) begin
         st = SC_DIG;
         add_digit(5'(c - 8'h30));
      end else if (c_alpha(c)) st = SC_IDENT;
      else begin
         case (c)
            "<", ">", "=", "!", "|", "&", "+", "-", "*", "/": begin
               held = c;
               st = SC_OP1;
            end
            "\"": st = SC_STR;
            "'": st = SC_COPEN;
            ".": st = SC_FRAC;
            default: push_token(c, ctok_pkg::MOD_NONE, pos, pos + 16'd1, 0, 0,
                                c >= 8'd128 ? ctok_pkg::E_BAD : ctok_pkg::E_NONE);
         endcase
      end
   endtask

   task automatic scan_byte(logic [7:0] c);
      step_out.delete();
      if (!continue_token(c)) begin_token(c);
      if (c == 0) begin
         pos = 0;
         st = SC_IDLE;
      end else pos = pos + 16'd1;
      if (step_out.size() > 0) step_out[$].last = 1'b1;
      foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic compare_token(ctok_pkg::result_type got);
      ctok_pkg::result_type w;
      if (expected_tokens.size() == 0) begin
         $display("%0t ns: token kind %0h arrived with none expected", $time, got.kind);
         fail_count++;
         return;
      end
      w = expected_tokens.pop_front();
      if (got.kind != w.kind) report("kind", got.kind, w.kind);
      if (got.modifier != w.modifier) report("modifier", got.modifier, w.modifier);
      if (got.start_pos != w.start_pos) report("start_pos", got.start_pos, w.start_pos);
      if (got.end_pos != w.end_pos) report("end_pos", got.end_pos, w.end_pos);
      if (got.int_value != w.int_value) report("int_value", got.int_value, w.int_value);
      if (got.char_value != w.char_value) report("char_value", got.char_value, w.char_value);
      if (got.error_code != w.error_code) report("error_code", got.error_code, w.error_code);
      if (got.last != w.last) report("last", got.last, w.last);
   endtask

   initial begin
      fail_count = 0;
      token_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         st = SC_IDLE;
         pos = 0;
         tok_start = 0;
         acc = 0;
         radix = ctok_pkg::RADIX_10;
         held = 0;
         err = ctok_pkg::E_NONE;
         limit = ctok_pkg::INT_LIMIT_RESET;
         expected_tokens.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            compare_token(rsp_token);
            token_count++;
         end
         if (cfg_we) limit = cfg_wdata;
         if (req_valid && req_ready) scan_byte(req_ch);
      end
      pending = expected_tokens.size();
   end
endmodule

/* verif/tb_c_like_token_scanner_top.sv */
// ----------------------------------------------------------------------------
// tb_c_like_token_scanner_top
// Feeds source text to the token scanner: directed snippets, then random
// well-formed C-like fragments mixed with noise, under several integer limits,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_c_like_token_scanner_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset;
   logic                 csr_psel, csr_penable, csr_pwrite;
   logic [2:0]           csr_paddr;
   logic [31:0]          csr_pwdata, csr_prdata;
   logic                 csr_pready;
   int                   fail_count, pending, token_count, cycle_count, byte_count;
   bit                   long_hold;
   ctok_pkg::result_type rsp_token;

   ctok_req_if req_bus ();
   ctok_rsp_if rsp_bus ();

   c_like_token_scanner_top DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   assign rsp_token = '{rsp_bus.kind, rsp_bus.modifier, rsp_bus.start_pos, rsp_bus.end_pos,
                        rsp_bus.int_value, rsp_bus.char_value, rsp_bus.error_code,
                        rsp_bus.last};

   ctok_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_bus.valid), .req_ready(req_bus.ready), .req_ch(req_bus.ch),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready), .rsp_token(rsp_token),
      .cfg_we(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_wdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending), .token_count(token_count)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d tokens outstanding", pending);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Token sink: random stalls, plus one long hold-off requested by the stimulus.
   initial begin
      int gap;
      rsp_bus.ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_bus.ready <= 0;
            repeat (60) @(posedge clock);
            long_hold = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_bus.ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1;
         @(posedge clock iff rsp_bus.valid);
      end
   end

   task automatic csr_write(logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= 3'(4 * ctok_pkg::REG_INT_LIMIT);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock iff csr_pready);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   // Valid stays high after an accepted request; a gap or a pause drops it.
   task automatic send_byte(logic [7:0] c, bit no_gap = 0);
      int gap;
      gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.ch <= c;
      @(posedge clock iff req_bus.ready);
      byte_count++;
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic drain_tokens();
      req_bus.valid <= 0;
      @(posedge clock iff pending == 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic string pick(string opts[]);
      return opts[$urandom_range(0, opts.size() - 1)];
   endfunction

   function automatic string digits(string set, int n);
      string s;
      s = "";
      repeat (n) s = {s, string'(set[$urandom_range(0, set.len() - 1)])};
      return s;
   endfunction

   function automatic string random_fragment();
      string s;
      int lenq;
      int sp;
      s = "";
      case ($urandom_range(0, 11))
         0: s = {pick('{"x", "_a", "Q9", "id_"}), digits("az_09Z", $urandom_range(0, 4))};
         1: s = digits("0123456789", $urandom_range(1, 12));
         2: s = {pick('{"0x", "0X"}), digits("0123456789abcdefABCDEFg", $urandom_range(0, 10))};
         3: s = {pick('{"0b", "0B"}), digits("01012", $urandom_range(0, 34))};
         4: s = {"0", digits("012345678a", $urandom_range(0, 12))};
         5: s = {digits("0123456789", $urandom_range(0, 3)), ".",
                 digits("0123456789", $urandom_range(0, 3)),
                 pick('{"", "e5", "E-", "e+12", "e", "Ex"})};
         6: s = {"'", pick('{"a", " ", "\\n", "\\r", "\\t", "\\v", "\\f", "\\q", "Z", "\t"}),
                 pick('{"'", "'", "'", "x"})};
         7: begin
            lenq = $urandom_range(0, 6);
            s = {"\"", digits("ab \\n\\q1\t", lenq), "\""};
         end
         8, 9: s = pick('{"<", ">", "=", "!", "|", "&", "+", "-", "*", "/", "<<", ">>",
                         "<<=", ">>=", "==", "!=", "<=", ">=", "&&", "||", "++", "--",
                         "+=", "-=", "*=", "/=", "&=", "|=", "(", ";", "{", "%", "^"});
         10: begin
            // Space, the control characters 9 to 13, or two spaces.
            sp = $urandom_range(0, 6);
            if (sp == 6) s = "  ";
            else s = string'(8'((sp == 0) ? 32 : sp + 8));
         end
         default: s = string'(8'($urandom_range(1, 255)));
      endcase
      if ($urandom_range(0, 2) != 0) s = {s, pick('{" ", "", "\n", "+", ")", "."})};
      return s;
   endfunction

   initial begin
      int n;
      reset = 1;
      req_bus.valid = 0;
      req_bus.ch = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      long_hold = 0;
      byte_count = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: operators, numbers at the edges, literals, end of input inside tokens.
      send_text("a<b>c!<<=>>= 0 0x 0b 0x7fffffff 2147483648 09a 1.5e+ .e 'a' '\\q' '  ");
      send_text("\"s\\q");
      send_byte(8'h80);
      send_byte(8'hff);
      send_byte(8'd0);
      send_text("'");
      send_byte(8'd0);
      drain_tokens();

      for (int k = 0; k < 4; k++) begin
         case (k)
            0: csr_write(32'd0);
            1: csr_write(32'hFFFF_FFFF);
            2: csr_write(32'd255);
            default: csr_write(32'd1);
         endcase
         n = 0;
         while (n < 30) begin
            send_text(random_fragment());
            n++;
            if ($urandom_range(0, 40) == 0) send_byte(8'd0);
            // Sink holds off while bytes keep coming, so the queue fills up.
            if (k == 1 && n == 10) begin
               long_hold = 1;
               repeat (30) send_byte("+", 1);
            end
            if (k == 2 && n == 15) begin
               req_bus.valid <= 0;
               @(posedge clock iff pending == 0);
            end
         end
         send_byte(8'd0);
         drain_tokens();
      end
      csr_write(ctok_pkg::INT_LIMIT_RESET);
      repeat (15) send_text(random_fragment());
      send_byte(8'd0);
      drain_tokens();

      $display("Scanned %0d source bytes into %0d tokens under five integer limits,", byte_count,
               token_count);
      $display("with random gaps, a long output stall and a full drain mid-run.");
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
